FILE: hdl/sict_pkg.sv
// ----------------------------------------------------------------------------
// sict_pkg
// shared types and constants for the sorted junction count table
// ----------------------------------------------------------------------------
`default_nettype none
package sict_pkg;

	localparam int unsigned POS_W    = 31;
	localparam int unsigned STRAND_W = 2;
	localparam int unsigned ADD_W    = 32;
	localparam int unsigned CNT_W    = 64;
	localparam int unsigned SER_W    = 32;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_FLUSH
	} sict_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture the incoming transfer
		logic insert;  // apply the add to the table
		logic emit;    // present the entry under the read pointer
		logic advance; // step the read pointer
		logic clear;   // empty the table after a flush
	} sict_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;     // no entries held
		logic last_rd;   // read pointer at the final entry
		logic out_full;  // output register holds an untaken result
	} sict_status_t;

endpackage
`default_nettype wire

FILE: hdl/sorted_interval_count_table_core.sv
// ----------------------------------------------------------------------------
// sorted_interval_count_table_core
// sorted table of distinct junctions with saturating support counts
// ----------------------------------------------------------------------------
// usage
//  - input channel in_valid / in_stall carries action and the junction fields
//  - an add transfer has a capture step, then a parallel compare over all
//    entries and a shift insert, count update, or drop if the table is full
//  - a flush transfer emits each entry in sorted order, one per cycle through
//    the output register while the receiver takes them; an empty flush only
//    clears the drop flag
//  - output channel out_valid / out_stall; a stalled result holds and the
//    read-out pauses until it is taken
//  - in_stall stays high after the capture until the add or flush is done
//  - reset empties the table, zeroes the serial count and the drop flag;
//    entry storage itself is not cleared
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_interval_count_table_core #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire                           action,
	input  wire [sict_pkg::POS_W-1:0]     junc_start,
	input  wire [sict_pkg::POS_W-1:0]     junc_end,
	input  wire [sict_pkg::STRAND_W-1:0]  strand_code,
	input  wire [sict_pkg::ADD_W-1:0]     add_count,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic signed [31:0]            left_bound,
	output logic [sict_pkg::POS_W-1:0]    right_bound,
	output logic [sict_pkg::STRAND_W-1:0] out_strand,
	output logic [sict_pkg::CNT_W-1:0]    support,
	output logic [sict_pkg::SER_W-1:0]    serial,
	output logic                          overflow,
	output logic                          last
);

	sict_pkg::sict_cmd_t    cmd;
	sict_pkg::sict_status_t status;

	// sequencer
	sict_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// table and read-out
	sict_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.junc_start  (junc_start),
		.junc_end    (junc_end),
		.strand_code (strand_code),
		.add_count   (add_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_bound  (left_bound),
		.right_bound (right_bound),
		.out_strand  (out_strand),
		.support     (support),
		.serial      (serial),
		.overflow    (overflow),
		.last        (last)
	);

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.emit)
		else $error("result overwritten while stalled");

	// no input taken while a flush or insert is in progress
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert || cmd.emit) |-> in_stall)
		else $error("input open while busy");

	// serial steps by one between consecutive results
	a_serial_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.emit) && cmd.emit |=> serial == $past(serial) + 32'd1)
		else $error("serial skipped");

endmodule
`default_nettype wire

FILE: hdl/sict_ctrl.sv
// ----------------------------------------------------------------------------
// sict_ctrl
// sequencer for add and flush transfers
// ----------------------------------------------------------------------------
`default_nettype none
module sict_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  action,
	input  sict_pkg::sict_status_t status,
	output logic                 in_stall,
	output sict_pkg::sict_cmd_t  cmd
);

	sict_pkg::sict_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sict_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			sict_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (action == sict_pkg::ACT_FLUSH) begin
						state_d = sict_pkg::ST_FLUSH;
					end else begin
						state_d = sict_pkg::ST_INSERT;
					end
				end
			end
			sict_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = sict_pkg::ST_IDLE;
			end
			sict_pkg::ST_FLUSH: begin
				if (status.empty) begin
					cmd.clear = 1'b1;
					state_d   = sict_pkg::ST_IDLE;
				end else if (!status.out_full) begin
					cmd.emit    = 1'b1;
					cmd.advance = 1'b1;
					if (status.last_rd) begin
						cmd.clear = 1'b1;
						state_d   = sict_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sict_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/sict_dp.sv
// ----------------------------------------------------------------------------
// sict_dp
// entry table with parallel compare and shift insert, flush read-out
// ----------------------------------------------------------------------------
`default_nettype none
module sict_dp #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  sict_pkg::sict_cmd_t             cmd,
	output sict_pkg::sict_status_t          status,
	input  wire [sict_pkg::POS_W-1:0]       junc_start,
	input  wire [sict_pkg::POS_W-1:0]       junc_end,
	input  wire [sict_pkg::STRAND_W-1:0]    strand_code,
	input  wire [sict_pkg::ADD_W-1:0]       add_count,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic signed [31:0]              left_bound,
	output logic [sict_pkg::POS_W-1:0]      right_bound,
	output logic [sict_pkg::STRAND_W-1:0]   out_strand,
	output logic [sict_pkg::CNT_W-1:0]      support,
	output logic [sict_pkg::SER_W-1:0]      serial,
	output logic                            overflow,
	output logic                            last
);

	localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned KEY_W  = 2 * sict_pkg::POS_W + sict_pkg::STRAND_W;

	logic [KEY_W-1:0]              key_q [TABLE_DEPTH];
	logic [sict_pkg::CNT_W-1:0]    cnt_q [TABLE_DEPTH];
	logic [FILL_W-1:0]             fill_q;
	logic [FILL_W-1:0]             rd_q;
	logic [sict_pkg::SER_W-1:0]    serial_q;
	logic                          drop_q;
	logic [KEY_W-1:0]              in_key_q;
	logic [sict_pkg::ADD_W-1:0]    in_cnt_q;

	// per entry compare, independent lanes
	logic [TABLE_DEPTH-1:0] valid_v, eq_v, gt_v;
	logic                   hit;
	logic [sict_pkg::CNT_W:0] sum_w [TABLE_DEPTH];

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			valid_v[i] = (FILL_W'(i) < fill_q);
			eq_v[i]    = valid_v[i] && (key_q[i] == in_key_q);
			gt_v[i]    = valid_v[i] && (key_q[i] > in_key_q);
			sum_w[i]   = {1'b0, cnt_q[i]} + {{(sict_pkg::CNT_W-sict_pkg::ADD_W+1){1'b0}}, in_cnt_q};
		end
		hit = |eq_v;
	end

	logic full;
	assign full = (fill_q == FILL_W'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_key_q <= {junc_start, junc_end, strand_code};
			in_cnt_q <= add_count;
		end
		if (cmd.insert) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (hit) begin
					if (eq_v[i]) begin
						cnt_q[i] <= sum_w[i][sict_pkg::CNT_W] ? '1 : sum_w[i][sict_pkg::CNT_W-1:0];
					end
				end else if (!full) begin
					// shift up entries above the slot, write the slot
					if (gt_v[i] && i > 0) begin
						if (!gt_v[(i > 0) ? i-1 : 0] || !valid_v[(i > 0) ? i-1 : 0]) begin
							key_q[i] <= in_key_q;
							cnt_q[i] <= {{(sict_pkg::CNT_W-sict_pkg::ADD_W){1'b0}}, in_cnt_q};
						end else begin
							key_q[i] <= key_q[(i > 0) ? i-1 : 0];
							cnt_q[i] <= cnt_q[(i > 0) ? i-1 : 0];
						end
					end
					if (gt_v[i] && i == 0) begin
						key_q[i] <= in_key_q;
						cnt_q[i] <= {{(sict_pkg::CNT_W-sict_pkg::ADD_W){1'b0}}, in_cnt_q};
					end
					if (FILL_W'(i) == fill_q) begin
						if (i > 0 && gt_v[(i > 0) ? i-1 : 0]) begin
							key_q[i] <= key_q[(i > 0) ? i-1 : 0];
							cnt_q[i] <= cnt_q[(i > 0) ? i-1 : 0];
						end else begin
							key_q[i] <= in_key_q;
							cnt_q[i] <= {{(sict_pkg::CNT_W-sict_pkg::ADD_W){1'b0}}, in_cnt_q};
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_q     <= '0;
			serial_q <= '0;
			drop_q   <= 1'b0;
		end else begin
			if (cmd.insert && !hit) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				serial_q <= serial_q + 1'b1;
			end
			if (cmd.advance) begin
				rd_q <= rd_q + 1'b1;
			end
			if (cmd.clear) begin
				fill_q <= '0;
				rd_q   <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	// output register
	logic [IDX_W-1:0] rd_idx;
	assign rd_idx = rd_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left_bound  <= $signed({1'b0, key_q[rd_idx][KEY_W-1 -: sict_pkg::POS_W]} - 32'd1);
			right_bound <= key_q[rd_idx][sict_pkg::STRAND_W +: sict_pkg::POS_W];
			out_strand  <= key_q[rd_idx][sict_pkg::STRAND_W-1:0];
			support     <= cnt_q[rd_idx];
			serial      <= serial_q + 1'b1;
			overflow    <= drop_q;
			last        <= status.last_rd;
		end
	end

	assign status.empty    = (fill_q == '0);
	assign status.last_rd  = (rd_q + 1'b1 == fill_q);
	assign status.out_full = out_valid && out_stall;

endmodule
`default_nettype wire
